>>> hw/rtl/trre_pkg.sv
package trre_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned VALUE_W     = 33;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned SIDES_W     = 16;
    localparam int unsigned BIT_W       = 5;
    localparam int unsigned S_TDATA_W   = 184;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [WORD_W-1:0]  COMP_ONE_RESET   = 32'd390451501;
    localparam logic [WORD_W-1:0]  COMP_TWO_RESET   = 32'd613566701;
    localparam logic [WORD_W-1:0]  COMP_THREE_RESET = 32'd858993401;

    localparam logic [WORD_W-1:0]  SEED_ONE_MIN   = 32'h0008_0000;
    localparam logic [WORD_W-1:0]  SEED_TWO_MIN   = 32'h0200_0000;
    localparam logic [WORD_W-1:0]  SEED_THREE_MIN = 32'h0000_0800;

    localparam logic [COUNT_W-1:0] DICE_COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_SEED  = 2'd0,
        MODE_RAW   = 2'd1,
        MODE_RANGE = 2'd2,
        MODE_DICE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/tausworthe_random_range_engine_top.sv
// Combined Tausworthe (taus88) random engine with range and dice requests.
// Input channel s_axis: one beat is one request; tuser carries the mode
// (seed, raw draw, range draw, dice roll), tdata the seeds, range ends and
// dice parameters. Output channel m_axis: exactly one beat per request,
// tdata the 33-bit signed value, tuser the error flag.
// Sequence from acceptance to the output register: seed and raw requests go
// through one generator step (ST_STEP) and ST_DONE. A range draw makes tries
// of one generator step, a pass of the shared bit-serial remainder unit over
// the 32 bits of the word and one compare; a try repeats while the remainder
// falls below the lower end. A dice roll makes such tries for each die and
// sums the dice. Empty ranges, zero-sided dice and zero dice go straight to
// ST_DONE and answer without stepping.
// Throughput: one request at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits; a stalled receiver holds the sequencer
// in its final state until the output register frees.
// Reset (synchronous, active low) loads the three components with their
// fixed start values and empties the output register.
module tausworthe_random_range_engine_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // seed_a, seed_b, seed_c, range_low, range_high, dice_count, dice_sides
    input  logic [trre_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // mode
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // value, zero padding
    output logic [trre_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // error
    output logic                                m_axis_tuser
);

    trre_pkg::t_state r_state, n_state;
    trre_pkg::t_mode  r_mode, n_mode;

    logic [trre_pkg::WORD_W-1:0]  r_c1, n_c1, r_c2, n_c2, r_c3, n_c3;
    logic [trre_pkg::WORD_W-1:0]  r_word, n_word;
    logic [trre_pkg::VALUE_W-1:0] r_rem, n_rem;
    logic [trre_pkg::VALUE_W-1:0] r_mod, n_mod;
    logic [trre_pkg::VALUE_W-1:0] r_lo, n_lo;
    logic [trre_pkg::VALUE_W-1:0] r_off, n_off;
    logic [trre_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic [trre_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic [trre_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic                         r_neg, n_neg;
    logic                         r_err, n_err;
    logic [trre_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    logic                         r_out_error, n_out_error;
    logic                         r_out_valid, n_out_valid;

    logic [trre_pkg::WORD_W-1:0]  seed_a, seed_b, seed_c;
    logic signed [33:0]           lo_x, hi_x;
    logic [trre_pkg::COUNT_W-1:0] dice_count;
    logic [trre_pkg::SIDES_W-1:0] dice_sides;

    logic [trre_pkg::WORD_W-1:0]  t1, t2, t3, a1, a2, a3, a_word;
    logic [33:0]                  trial;
    logic [trre_pkg::VALUE_W-1:0] adj;
    logic                         s_acc;

    assign seed_a     = s_axis_tdata[31:0];
    assign seed_b     = s_axis_tdata[63:32];
    assign seed_c     = s_axis_tdata[95:64];
    assign lo_x       = signed'({{2{s_axis_tdata[127]}}, s_axis_tdata[127:96]});
    assign hi_x       = signed'({{2{s_axis_tdata[159]}}, s_axis_tdata[159:128]});
    assign dice_count = s_axis_tdata[167:160];
    assign dice_sides = s_axis_tdata[183:168];

    assign s_axis_tready = (r_state == trre_pkg::ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_value};
    assign m_axis_tuser  = r_out_error;

    // one generator step
    assign t1     = ((r_c1 << 13) ^ r_c1) >> 19;
    assign a1     = ((r_c1 & 32'hFFFF_FFFE) << 12) ^ t1;
    assign t2     = ((r_c2 << 2) ^ r_c2) >> 25;
    assign a2     = ((r_c2 & 32'hFFFF_FFF8) << 4) ^ t2;
    assign t3     = ((r_c3 << 3) ^ r_c3) >> 11;
    assign a3     = ((r_c3 & 32'hFFFF_FFF0) << 17) ^ t3;
    assign a_word = a1 ^ a2 ^ a3;

    // one restoring remainder step
    assign trial = {r_rem, r_word[31]};
    assign adj   = r_neg ? (trre_pkg::VALUE_W'(0) - r_rem) : (r_rem + r_off);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_c1        = r_c1;
        n_c2        = r_c2;
        n_c3        = r_c3;
        n_word      = r_word;
        n_rem       = r_rem;
        n_mod       = r_mod;
        n_lo        = r_lo;
        n_off       = r_off;
        n_acc       = r_acc;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_err       = r_err;
        n_out_value = r_out_value;
        n_out_error = r_out_error;
        n_out_valid = r_out_valid && !m_axis_tready;

        case (r_state)
            trre_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_mode  = trre_pkg::t_mode'(s_axis_tuser);
                    n_acc   = '0;
                    n_err   = 1'b0;
                    n_off   = '0;
                    n_neg   = 1'b0;
                    n_cnt   = trre_pkg::COUNT_W'(1);
                    n_state = trre_pkg::ST_STEP;
                    case (trre_pkg::t_mode'(s_axis_tuser))
                        trre_pkg::MODE_SEED: begin
                            if (seed_a > trre_pkg::SEED_ONE_MIN)   n_c1 = seed_a;
                            if (seed_b > trre_pkg::SEED_TWO_MIN)   n_c2 = seed_b;
                            if (seed_c > trre_pkg::SEED_THREE_MIN) n_c3 = seed_c;
                        end
                        trre_pkg::MODE_RANGE: begin
                            if (lo_x > hi_x) begin
                                n_err   = 1'b1;
                                n_state = trre_pkg::ST_DONE;
                            end else if (lo_x >= 0) begin
                                n_lo  = lo_x[32:0];
                                n_mod = 33'(hi_x + 34'sd1);
                            end else if (hi_x >= 0) begin
                                n_lo  = '0;
                                n_mod = 33'(hi_x - lo_x + 34'sd1);
                                n_off = lo_x[32:0];
                            end else begin
                                n_lo  = 33'(-hi_x);
                                n_mod = 33'(34'sd1 - lo_x);
                                n_neg = 1'b1;
                            end
                        end
                        trre_pkg::MODE_DICE: begin
                            n_lo  = trre_pkg::VALUE_W'(1);
                            n_mod = trre_pkg::VALUE_W'(dice_sides) + trre_pkg::VALUE_W'(1);
                            n_cnt = (dice_count > trre_pkg::DICE_COUNT_MAX) ?
                                    trre_pkg::DICE_COUNT_MAX : dice_count;
                            if (dice_sides == '0) begin
                                n_err   = 1'b1;
                                n_state = trre_pkg::ST_DONE;
                            end else if (dice_count == '0) begin
                                n_state = trre_pkg::ST_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            trre_pkg::ST_STEP: begin
                n_c1   = a1;
                n_c2   = a2;
                n_c3   = a3;
                n_word = a_word;
                n_rem  = '0;
                n_bit  = '0;
                case (r_mode)
                    trre_pkg::MODE_SEED: begin
                        n_state = trre_pkg::ST_DONE;
                    end
                    trre_pkg::MODE_RAW: begin
                        n_acc   = {1'b0, a_word};
                        n_state = trre_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = trre_pkg::ST_DIV;
                    end
                endcase
            end
            trre_pkg::ST_DIV: begin
                if (trial >= {1'b0, r_mod}) begin
                    n_rem = 33'(trial - {1'b0, r_mod});
                end else begin
                    n_rem = trial[32:0];
                end
                n_word = r_word << 1;
                n_bit  = r_bit + 1'b1;
                if (r_bit == '1) begin
                    n_state = trre_pkg::ST_CHECK;
                end
            end
            trre_pkg::ST_CHECK: begin
                if (r_rem < r_lo) begin
                    n_state = trre_pkg::ST_STEP;
                end else begin
                    n_acc = r_acc + adj;
                    n_cnt = r_cnt - 1'b1;
                    n_state = (r_cnt == trre_pkg::COUNT_W'(1)) ?
                              trre_pkg::ST_DONE : trre_pkg::ST_STEP;
                end
            end
            trre_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_value = r_err ? '0 : r_acc;
                    n_out_error = r_err;
                    n_out_valid = 1'b1;
                    n_state     = trre_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = trre_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trre_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_c1        <= trre_pkg::COMP_ONE_RESET;
            r_c2        <= trre_pkg::COMP_TWO_RESET;
            r_c3        <= trre_pkg::COMP_THREE_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_c1        <= n_c1;
            r_c2        <= n_c2;
            r_c3        <= n_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_word      <= n_word;
        r_rem       <= n_rem;
        r_mod       <= n_mod;
        r_lo        <= n_lo;
        r_off       <= n_off;
        r_acc       <= n_acc;
        r_bit       <= n_bit;
        r_cnt       <= n_cnt;
        r_neg       <= n_neg;
        r_err       <= n_err;
        r_out_value <= n_out_value;
        r_out_error <= n_out_error;
    end

endmodule

>>> hw/rtl/trre_chk.sv
module trre_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [trre_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input logic [1:0]                         s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [trre_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input logic                               m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error beat carries a nonzero value");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[trre_pkg::M_TDATA_W-1:trre_pkg::VALUE_W] == '0)
        else $error("output padding not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle and empty after reset");

endmodule

bind tausworthe_random_range_engine_top trre_chk u_trre_chk (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned IDLE_LIMIT      = 100000;
    localparam int unsigned RANDOM_ITEMS    = 1450;
    localparam int unsigned DRAIN_CYCLES    = 100;
    localparam int unsigned PRESSURE_CYCLES = 2500;
    localparam int unsigned IDLE_PERCENT    = 34;

    typedef struct {
        trre_pkg::t_mode                  mode;
        logic [trre_pkg::WORD_W-1:0]      seed_a;
        logic [trre_pkg::WORD_W-1:0]      seed_b;
        logic [trre_pkg::WORD_W-1:0]      seed_c;
        logic signed [31:0]               range_low;
        logic signed [31:0]               range_high;
        logic [trre_pkg::COUNT_W-1:0]     dice_count;
        logic [trre_pkg::SIDES_W-1:0]     dice_sides;
    } t_engine_request;

    typedef struct {
        logic [trre_pkg::VALUE_W-1:0]     value;
        logic                             error;
    } t_engine_answer;

    logic                                 i_clk         = 1'b0;
    logic                                 i_rst_n       = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [trre_pkg::S_TDATA_W-1:0]       s_axis_tdata  = '0;
    logic [1:0]                           s_axis_tuser  = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [trre_pkg::M_TDATA_W-1:0]       m_axis_tdata;
    logic                                 m_axis_tuser;

    t_engine_answer         pending_answers[$];
    int unsigned            mismatch_count = 0;
    int unsigned            idle_cycles    = 0;
    bit                     tx_gaps_on     = 1'b1;
    bit                     rx_stalls_on   = 1'b1;
    bit                     rx_hold_toggle = 1'b0;
    bit                     rx_hold_ack    = 1'b0;
    int unsigned            rx_hold_left   = 0;

    logic [trre_pkg::WORD_W-1:0]          taus_one;
    logic [trre_pkg::WORD_W-1:0]          taus_two;
    logic [trre_pkg::WORD_W-1:0]          taus_three;

    tausworthe_random_range_engine_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [trre_pkg::WORD_W-1:0] taus_advance();
        logic [trre_pkg::WORD_W-1:0] t;
        t          = ((taus_one << 13) ^ taus_one) >> 19;
        taus_one   = ((taus_one & 32'hFFFF_FFFE) << 12) ^ t;
        t          = ((taus_two << 2) ^ taus_two) >> 25;
        taus_two   = ((taus_two & 32'hFFFF_FFF8) << 4) ^ t;
        t          = ((taus_three << 3) ^ taus_three) >> 11;
        taus_three = ((taus_three & 32'hFFFF_FFF0) << 17) ^ t;
        return taus_one ^ taus_two ^ taus_three;
    endfunction

    // reject words whose remainder falls below lo; one step per try
    function automatic longint draw_span(longint lo, longint hi);
        longint unsigned modulus;
        longint unsigned rem;
        modulus = hi + 1;
        do begin
            rem = {32'd0, taus_advance()} % modulus;
        end while (rem < $unsigned(lo));
        return longint'(rem);
    endfunction

    function automatic t_engine_answer predict_answer(t_engine_request req);
        t_engine_answer ans;
        longint         total;
        longint         lo;
        longint         hi;
        int unsigned    count;
        total     = 0;
        ans.error = 1'b0;
        case (req.mode)
            trre_pkg::MODE_SEED: begin
                if (req.seed_a > trre_pkg::SEED_ONE_MIN) taus_one = req.seed_a;
                if (req.seed_b > trre_pkg::SEED_TWO_MIN) taus_two = req.seed_b;
                if (req.seed_c > trre_pkg::SEED_THREE_MIN) taus_three = req.seed_c;
                void'(taus_advance());
            end
            trre_pkg::MODE_RAW: begin
                total = longint'({32'd0, taus_advance()});
            end
            trre_pkg::MODE_RANGE: begin
                lo = longint'(req.range_low);
                hi = longint'(req.range_high);
                if (lo > hi) begin
                    ans.error = 1'b1;
                end else if (lo >= 0) begin
                    total = draw_span(lo, hi);
                end else if (hi >= 0) begin
                    total = draw_span(0, hi - lo) + lo;
                end else begin
                    total = -draw_span(-hi, -lo);
                end
            end
            trre_pkg::MODE_DICE: begin
                count = {24'd0, req.dice_count};
                if (count > {24'd0, trre_pkg::DICE_COUNT_MAX}) begin
                    count = {24'd0, trre_pkg::DICE_COUNT_MAX};
                end
                hi = longint'({48'd0, req.dice_sides});
                if (hi == 0) begin
                    ans.error = 1'b1;
                end else begin
                    for (int unsigned i = 0; i < count; i++) total += draw_span(1, hi);
                end
            end
            default: begin
            end
        endcase
        ans.value = total[trre_pkg::VALUE_W-1:0];
        return ans;
    endfunction

    function automatic t_engine_request random_request(trre_pkg::t_mode mode);
        t_engine_request req;
        req.mode       = mode;
        req.seed_a     = $urandom;
        req.seed_b     = $urandom;
        req.seed_c     = $urandom;
        req.range_low  = $urandom;
        req.range_high = $urandom;
        req.dice_count = trre_pkg::COUNT_W'($urandom);
        req.dice_sides = trre_pkg::SIDES_W'($urandom);
        return req;
    endfunction

    task automatic send_request(t_engine_request req);
        int unsigned gap;
        gap = 0;
        if (tx_gaps_on) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.mode;
        s_axis_tdata  <= {req.dice_sides, req.dice_count, req.range_high, req.range_low,
                          req.seed_c, req.seed_b, req.seed_a};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_answers.push_back(predict_answer(req));
    endtask

    task automatic send_seed(logic [trre_pkg::WORD_W-1:0] a, logic [trre_pkg::WORD_W-1:0] b,
                             logic [trre_pkg::WORD_W-1:0] c);
        t_engine_request req;
        req        = random_request(trre_pkg::MODE_SEED);
        req.seed_a = a;
        req.seed_b = b;
        req.seed_c = c;
        send_request(req);
    endtask

    task automatic send_raw();
        send_request(random_request(trre_pkg::MODE_RAW));
    endtask

    task automatic send_range(logic signed [31:0] lo, logic signed [31:0] hi);
        t_engine_request req;
        req            = random_request(trre_pkg::MODE_RANGE);
        req.range_low  = lo;
        req.range_high = hi;
        send_request(req);
    endtask

    task automatic send_dice(logic [trre_pkg::COUNT_W-1:0] count,
                             logic [trre_pkg::SIDES_W-1:0] sides);
        t_engine_request req;
        req            = random_request(trre_pkg::MODE_DICE);
        req.dice_count = count;
        req.dice_sides = sides;
        send_request(req);
    endtask

    // keep the acceptance rate of each draw at one half or better
    task automatic send_random_range();
        int unsigned        top;
        int unsigned        mag_lo;
        int unsigned        mag_hi;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] tmp;
        top = 32'h7FFF_FFFF >> $urandom_range(0, 30);
        case ($urandom_range(0, 3))
            0: begin
                mag_hi = $urandom_range(0, top);
                mag_lo = $urandom_range(0, mag_hi / 2);
                lo     = mag_lo;
                hi     = mag_hi;
            end
            1: begin
                mag_lo = $urandom_range(1, top);
                lo     = -mag_lo;
                hi     = $urandom_range(0, 32'h7FFF_FFFF >> $urandom_range(0, 30));
            end
            2: begin
                mag_lo = $urandom_range(1, top);
                mag_hi = $urandom_range(1, (mag_lo + 1) / 2);
                lo     = -mag_lo;
                hi     = -mag_hi;
            end
            default: begin
                lo = $urandom;
                hi = $urandom;
                if (lo == hi) hi = lo ^ 32'd1;
                if (lo < hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
        endcase
        send_range(lo, hi);
    endtask

    task automatic send_random_dice();
        logic [trre_pkg::COUNT_W-1:0] count;
        logic [trre_pkg::SIDES_W-1:0] sides;
        if ($urandom_range(0, 59) == 0) count = trre_pkg::COUNT_W'($urandom_range(128, 255));
        else count = trre_pkg::COUNT_W'($urandom_range(0, 6));
        if ($urandom_range(0, 19) == 0) begin
            sides = '0;
        end else begin
            sides = trre_pkg::SIDES_W'($urandom_range(1, 16'hFFFF) >> $urandom_range(0, 15));
            if (sides == 0) sides = 1;
        end
        send_dice(count, sides);
    endtask

    task automatic test_seed_thresholds();
        send_seed(trre_pkg::SEED_ONE_MIN, trre_pkg::SEED_TWO_MIN, trre_pkg::SEED_THREE_MIN);
        send_raw();
        send_seed(trre_pkg::SEED_ONE_MIN + 32'd1, trre_pkg::SEED_TWO_MIN + 32'd1,
                  trre_pkg::SEED_THREE_MIN + 32'd1);
        send_raw();
        send_seed('0, '0, '0);
        send_raw();
        send_seed('1, '1, '1);
        send_raw();
    endtask

    task automatic test_range_corners();
        send_range(-32'sd2147483647, 32'sd2147483646);
        send_range(32'sd0, 32'sd2147483646);
        send_range(32'sd0, 32'sd0);
        send_range(32'sd7, 32'sd7);
        send_range(-32'sd2147483647, -32'sd1);
        send_range(-32'sd1, -32'sd1);
        send_range(32'h8000_0000, 32'h7FFF_FFFF);
        send_range(32'h8000_0000, -32'sd1);
        send_range(32'sd2147483646, -32'sd2147483647);
        send_range(32'sd5, 32'sd4);
    endtask

    task automatic test_dice_corners();
        send_dice(8'd255, 16'hFFFF);
        send_dice(8'd0, 16'd5);
        send_dice(8'd0, 16'd0);
        send_dice(8'd3, 16'd0);
        send_dice(8'd255, 16'd1);
        send_dice(8'd1, 16'd1);
    endtask

    task automatic test_backpressure();
        tx_gaps_on     = 1'b0;
        rx_hold_toggle = ~rx_hold_toggle;
        repeat (6) send_raw();
        tx_gaps_on     = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 500) begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            if (i == 800) begin
                tx_gaps_on   = 1'b1;
                rx_stalls_on = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_seed($urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
                          $urandom >> $urandom_range(0, 31));
            end else if (pick < 35) begin
                send_raw();
            end else if (pick < 75) begin
                send_random_range();
            end else begin
                send_random_dice();
            end
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // hold off for a long stretch on request, else stall at random while stalls are on
    always @(posedge i_clk) begin
        if (rx_hold_toggle != rx_hold_ack) begin
            rx_hold_ack   <= rx_hold_toggle;
            rx_hold_left  = PRESSURE_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_stalls_on) begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_engine_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, tdata %h",
                                          m_axis_tdata));
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[trre_pkg::VALUE_W-1:0] !== want.value)
                    report_mismatch($sformatf("value %h, want %h",
                                              m_axis_tdata[trre_pkg::VALUE_W-1:0],
                                              want.value));
                if (m_axis_tdata[trre_pkg::M_TDATA_W-1:trre_pkg::VALUE_W] !== '0)
                    report_mismatch($sformatf("padding %h not zero",
                                    m_axis_tdata[trre_pkg::M_TDATA_W-1:trre_pkg::VALUE_W]));
                if (m_axis_tuser !== want.error)
                    report_mismatch($sformatf("error %b, want %b", m_axis_tuser, want.error));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tausworthe_random_range_engine_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        taus_one   = trre_pkg::COMP_ONE_RESET;
        taus_two   = trre_pkg::COMP_TWO_RESET;
        taus_three = trre_pkg::COMP_THREE_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_seed_thresholds();
        test_range_corners();
        test_dice_corners();
        test_backpressure();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tausworthe_random_range_engine_top regression: pass");
        end else begin
            $display("tausworthe_random_range_engine_top regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/trre_pkg.sv
hw/rtl/tausworthe_random_range_engine_top.sv
hw/rtl/trre_chk.sv
tb/tb.sv
